// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rhc_pkg.sv =====
`timescale 1ns / 1ps
package rhc_pkg;

  localparam int unsigned ChannelBits = 8;
  localparam int unsigned HueBits     = 9;
  localparam int unsigned QuoBits     = 9;
  localparam int unsigned NumBits     = ChannelBits + QuoBits;
  localparam int unsigned StepsPerStg = 3;
  localparam int unsigned DivStages   = (QuoBits + StepsPerStg - 1) / StepsPerStg;

  localparam int unsigned HueFull  = 360;
  localparam int unsigned HueGreen = 120;
  localparam int unsigned HueBlue  = 240;
  localparam int unsigned HueScale = 60;

  typedef logic [ChannelBits-1:0] chan_t;
  typedef logic [HueBits-1:0]     hue_t;
  typedef logic [NumBits-1:0]     num_t;
  typedef logic [QuoBits-1:0]     quo_t;

  typedef struct packed {
    logic [DivStages-1:0] en;
  } rhc_div_ctrl_t;

endpackage

// ===== rtl/core/rhc_if.sv =====
`timescale 1ns / 1ps
interface rhc_pix_if;
  logic                          valid;
  logic                          ready;
  logic [rhc_pkg::ChannelBits-1:0] red;
  logic [rhc_pkg::ChannelBits-1:0] green;
  logic [rhc_pkg::ChannelBits-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsv_if;
  logic                            valid;
  logic                            ready;
  logic [rhc_pkg::HueBits-1:0]     hue_degrees;
  logic [rhc_pkg::ChannelBits-1:0] saturation_level;
  logic [rhc_pkg::ChannelBits-1:0] value_level;

  modport source (output valid, output hue_degrees, output saturation_level,
                  output value_level, input ready);
  modport sink (input valid, input hue_degrees, input saturation_level,
                input value_level, output ready);
endinterface

// ===== rtl/core/rhc_div.sv =====
`timescale 1ns / 1ps
module rhc_div (
  input  logic                          clk_i,
  input  rhc_pkg::rhc_div_ctrl_t        ctrl_i,
  input  logic [rhc_pkg::NumBits-1:0]     dividend_i,
  input  logic [rhc_pkg::ChannelBits-1:0] divisor_i,
  output logic [rhc_pkg::QuoBits-1:0]     quotient_o
);
  import rhc_pkg::*;

  num_t  rem_q [DivStages];
  quo_t  quo_q [DivStages];
  chan_t div_q [DivStages];

  num_t  src_rem [DivStages];
  quo_t  src_quo [DivStages];
  chan_t src_div [DivStages];
  num_t  rem_d   [DivStages];
  quo_t  quo_d   [DivStages];

  always_comb begin
    num_t trial;
    num_t rem_w;
    quo_t quo_w;
    int   bit_idx;
    trial      = '0;
    src_rem[0] = dividend_i;
    src_quo[0] = '0;
    src_div[0] = divisor_i;
    for (int s = 1; s < DivStages; s++) begin
      src_rem[s] = rem_q[s-1];
      src_quo[s] = quo_q[s-1];
      src_div[s] = div_q[s-1];
    end
    for (int s = 0; s < DivStages; s++) begin
      rem_w = src_rem[s];
      quo_w = src_quo[s];
      for (int k = 0; k < StepsPerStg; k++) begin
        bit_idx = QuoBits - 1 - (s * StepsPerStg + k);
        if (bit_idx >= 0) begin
          trial = NumBits'(src_div[s]) << bit_idx;
          if (rem_w >= trial) begin
            rem_w = rem_w - trial;
            quo_w = quo_w | (QuoBits'(1) << bit_idx);
          end
        end
      end
      rem_d[s] = rem_w;
      quo_d[s] = quo_w;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DivStages; s++) begin
      if (ctrl_i.en[s]) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        div_q[s] <= src_div[s];
      end
    end
  end

  assign quotient_o = quo_q[DivStages-1];

endmodule

// ===== rtl/core/rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps
// RGB to HSV pixel converter.
// Pixels arrive on pix_i (red, green, blue, one channel width each) and results
// leave on hsv_o (hue in whole degrees, saturation and value). Both channels use
// a valid/ready handshake; a transfer happens on a rising edge with both high.
// One pixel may be transferred in every cycle while hsv_o.ready is high, so the
// sustained rate is one pixel per clock. The pipeline has six register stages:
// input capture, max/min and sector selection, numerator forming, then three
// stages of a restoring divider that resolve three quotient bits each for hue
// and saturation in parallel. A result is offered once its pixel has passed
// through every stage.
// Each stage advances when it is empty or when the stage after it advances, so a
// stalled receiver fills the pipeline from the output backwards and pix_i.ready
// falls only once every stage holds a pixel; bubbles are squeezed out meanwhile.
// Reset clears all stage valid bits, so no result is offered until new pixels
// arrive; the data registers are not reset.
module rgb_to_hsv_converter_top (
  input  logic clk_i,
  input  logic rst_ni,
  rhc_pix_if.sink   pix_i,
  rhc_hsv_if.source hsv_o
);
  import rhc_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  localparam int unsigned NumStages = 3 + DivStages;
  localparam int unsigned SgnBits   = NumBits + 1;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] en;

  chan_t s0_r_q, s0_g_q, s0_b_q;

  chan_t   s1_mx_q, s1_d_q;
  logic signed [ChannelBits:0] s1_diff_q;
  sector_e s1_sec_q;
  chan_t   s1_mx_d, s1_d_d, s1_mn_d;
  logic signed [ChannelBits:0] s1_diff_d;
  sector_e s1_sec_d;

  num_t  s2_hnum_q, s2_snum_q;
  chan_t s2_hdiv_q, s2_sdiv_q, s2_mx_q;
  num_t  s2_hnum_d, s2_snum_d;
  chan_t s2_hdiv_d, s2_sdiv_d;

  chan_t val_q [DivStages];

  logic signed [SgnBits-1:0] scaled;
  num_t          off_d;
  logic [HueBits-1:0] off;

  quo_t          hue_quo, sat_quo;
  rhc_div_ctrl_t div_ctrl;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || hsv_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];
  assign div_ctrl.en = en[NumStages-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= pix_i.valid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_comb begin
    if (s0_b_q >= s0_r_q && s0_b_q >= s0_g_q) begin
      s1_sec_d  = SEC_BLUE;
      s1_mx_d   = s0_b_q;
      s1_diff_d = $signed({1'b0, s0_r_q}) - $signed({1'b0, s0_g_q});
    end else if (s0_g_q >= s0_r_q) begin
      s1_sec_d  = SEC_GREEN;
      s1_mx_d   = s0_g_q;
      s1_diff_d = $signed({1'b0, s0_b_q}) - $signed({1'b0, s0_r_q});
    end else begin
      s1_sec_d  = SEC_RED;
      s1_mx_d   = s0_r_q;
      s1_diff_d = $signed({1'b0, s0_g_q}) - $signed({1'b0, s0_b_q});
    end
    s1_mn_d = (s0_r_q < s0_g_q) ? s0_r_q : s0_g_q;
    if (s0_b_q < s1_mn_d) begin
      s1_mn_d = s0_b_q;
    end
    s1_d_d = s1_mx_d - s1_mn_d;
  end

  always_comb begin
    unique case (s1_sec_q)
      SEC_BLUE:  off = HueBits'(HueBlue);
      SEC_GREEN: off = HueBits'(HueGreen);
      SEC_RED:   off = s1_diff_q[ChannelBits] ? HueBits'(HueFull) : '0;
      default:   off = '0;
    endcase
    scaled = SgnBits'(SgnBits'(s1_diff_q) * SgnBits'(HueScale));
    off_d  = NumBits'(NumBits'(s1_d_q) * NumBits'(off));
    if (s1_d_q == '0) begin
      s2_hnum_d = '0;
      s2_hdiv_d = ChannelBits'(1);
    end else begin
      s2_hnum_d = NumBits'(scaled + $signed({1'b0, off_d}));
      s2_hdiv_d = s1_d_q;
    end
    s2_snum_d = (NumBits'(s1_d_q) << ChannelBits) - NumBits'(s1_d_q);
    s2_sdiv_d = (s1_mx_q == '0) ? ChannelBits'(1) : s1_mx_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_r_q <= pix_i.red;
      s0_g_q <= pix_i.green;
      s0_b_q <= pix_i.blue;
    end
    if (en[1]) begin
      s1_mx_q   <= s1_mx_d;
      s1_d_q    <= s1_d_d;
      s1_diff_q <= s1_diff_d;
      s1_sec_q  <= s1_sec_d;
    end
    if (en[2]) begin
      s2_hnum_q <= s2_hnum_d;
      s2_hdiv_q <= s2_hdiv_d;
      s2_snum_q <= s2_snum_d;
      s2_sdiv_q <= s2_sdiv_d;
      s2_mx_q   <= s1_mx_q;
    end
    if (en[3]) begin
      val_q[0] <= s2_mx_q;
    end
    for (int s = 1; s < DivStages; s++) begin
      if (en[3+s]) begin
        val_q[s] <= val_q[s-1];
      end
    end
  end

  rhc_div u_hue_div (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .dividend_i (s2_hnum_q),
    .divisor_i  (s2_hdiv_q),
    .quotient_o (hue_quo)
  );

  rhc_div u_sat_div (
    .clk_i      (clk_i),
    .ctrl_i     (div_ctrl),
    .dividend_i (s2_snum_q),
    .divisor_i  (s2_sdiv_q),
    .quotient_o (sat_quo)
  );

  assign hsv_o.valid            = v_q[NumStages-1];
  assign hsv_o.hue_degrees      = HueBits'(hue_quo);
  assign hsv_o.saturation_level = sat_quo[ChannelBits-1:0];
  assign hsv_o.value_level      = val_q[DivStages-1];

  `RHC_ASSERT_SAME(a_hue_range, hsv_o.valid, hsv_o.hue_degrees < HueBits'(HueFull))
  `RHC_ASSERT_SAME(a_black_unsat, hsv_o.valid && hsv_o.value_level == '0,
                   hsv_o.saturation_level == '0)
  `RHC_ASSERT_SAME(a_grey_hue, hsv_o.valid && hsv_o.saturation_level == '0,
                   hsv_o.hue_degrees == '0)
  `RHC_ASSERT_SAME(a_empty_ready, v_q == '0, pix_i.ready)
  `RHC_ASSERT_NEXT(a_stall_full, !hsv_o.ready && v_q == '1, v_q == '1)

endmodule
